/* hdl/palr_pkg.sv */
// Package for the polyline arc-length resampler.
// Holds the channel payload structs, the arithmetic widths and the status structs of the
// shared divider and of the square-root unit. Depends on nothing.
package palr_pkg;

  localparam int CoordW = 32;
  localparam int RegW   = 20;
  localparam int IdxW   = 2;
  localparam int DistW  = 33;   // segment length, up to sqrt(2) * 2^32
  localparam int DivdW  = 53;   // |delta| * offset + d/2
  localparam int RadW   = 65;   // dx^2 + dy^2

  localparam logic [IdxW-1:0] REG_SAMPLE_STEP = 2'd0;
  localparam logic [IdxW-1:0] REG_MIN_TAIL    = 2'd1;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     last_vertex;
  } palr_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
    logic                     truncated;
  } palr_out_t;

  typedef struct packed {
    logic             done;
    logic [DivdW-1:0] quot;
    logic [DistW-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic             done;
    logic [DistW-1:0] root;
  } sqrt_res_t;

endpackage

/* hdl/palr_div.sv */
// Restoring divider, one quotient bit per cycle.
// Uses palr_pkg for widths and the result struct.
module palr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [palr_pkg::DivdW-1:0]  dividend,
  input  logic [palr_pkg::DistW-1:0]  divisor,
  output palr_pkg::div_res_t          res
);
  import palr_pkg::*;

  localparam int CntW = $clog2(DivdW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CntW-1:0]  cnt_r;
  logic [DivdW-1:0] quo_r;
  logic [DistW-1:0] rem_r;
  logic [DistW-1:0] dsr_r;
  logic [DistW:0]   trial;
  logic             take;

  assign trial = {rem_r, quo_r[DivdW-1]};
  assign take  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DivdW);
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DivdW-2:0], take};
        rem_r <= take ? DistW'(trial - {1'b0, dsr_r}) : trial[DistW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

/* hdl/palr_sqrt.sv */
// Integer square root, two radicand bits per cycle.
// Uses palr_pkg for widths and the result struct.
module palr_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [palr_pkg::RadW-1:0] radicand,
  output palr_pkg::sqrt_res_t       res
);
  import palr_pkg::*;

  localparam int PadW  = 2 * DistW;
  localparam int RemW  = DistW + 1;
  localparam int CntW  = $clog2(DistW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CntW-1:0]  cnt_r;
  logic [PadW-1:0]  rad_r;
  logic [RemW-1:0]  rem_r;
  logic [DistW-1:0] root_r;
  logic [RemW+1:0]  cur;
  logic [DistW-1:0] root_sh;
  logic [RemW+1:0]  trial;
  logic             take;

  assign cur     = {rem_r, rad_r[PadW-1 -: 2]};
  assign root_sh = {root_r[DistW-2:0], 1'b0};
  assign trial   = (RemW+2)'({root_sh, 1'b1});
  assign take    = cur >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DistW);
        rad_r  <= PadW'(radicand);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[PadW-3:0], 2'b00};
        rem_r  <= take ? RemW'(cur - trial) : RemW'(cur);
        root_r <= take ? (root_sh | DistW'(1)) : root_sh;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.root = root_r;

endmodule

/* hdl/polyline_arc_length_resampler.sv */
// Top level of the polyline arc-length resampler.
// Uses palr_pkg, palr_div and palr_sqrt.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_data              | vertices in
//  out     | out_valid, out_ready, out_data           | points out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register writes
//
// A first vertex of a path is stored, or dropped when it ends the path; in_ready stays high.
// Any other vertex goes through the squares on the one multiplier, the bit-serial root, the
// count division and the offset divisions (two, or four when more than one sample) on the
// bit-serial divider, then emits one point per cycle while out_ready is high; a segment too
// short for a sample skips the divisions, and an end vertex adds up to two output points.
// in_ready is low until the request is done. Reset is synchronous; cfg_ready is always high.
module polyline_arc_length_resampler #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  palr_pkg::palr_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output palr_pkg::palr_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [palr_pkg::IdxW-1:0]  cfg_index,
  input  logic [palr_pkg::RegW-1:0]  cfg_data
);
  import palr_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQX    = 4'd1;
  localparam logic [3:0] ST_SQY    = 4'd2;
  localparam logic [3:0] ST_SQRTGO = 4'd3;
  localparam logic [3:0] ST_SQRTW  = 4'd4;
  localparam logic [3:0] ST_SPLIT  = 4'd5;
  localparam logic [3:0] ST_RESTW  = 4'd6;
  localparam logic [3:0] ST_MUL    = 4'd7;
  localparam logic [3:0] ST_DIVS   = 4'd8;
  localparam logic [3:0] ST_DIVW   = 4'd9;
  localparam logic [3:0] ST_EMIT   = 4'd10;
  localparam logic [3:0] ST_FIN    = 4'd11;
  localparam logic [3:0] ST_OUTH   = 4'd12;
  localparam logic [3:0] ST_OUTL   = 4'd13;

  logic [3:0]        state_r;
  logic [RegW-1:0]   step_r, tail_r;
  logic [CoordW-1:0] prev_x_r, prev_y_r, held_x_r, held_y_r, cur_x_r, cur_y_r;
  logic              have_prev_r, held_valid_r, held_trunc_r, last_r;
  logic [1:0]        pushed_r;
  logic [RegW-1:0]   residual_r, a_r;
  logic [CoordW-1:0] mx_r, my_r;
  logic              nx_r, ny_r;
  logic [RadW-1:0]   acc_r;
  logic [DistW-1:0]  d_r, rest_r;
  logic [CW-1:0]     cnt_r;
  logic              tr_r;
  logic [1:0]        phase_r;
  logic [CoordW-1:0] qx_r, qy_r, qsx_r, qsy_r;
  logic [DistW-1:0]  rx_r, ry_r, rsx_r, rsy_r;
  logic              out_valid_r;
  palr_out_t         out_data_r;

  logic [RegW-1:0]     eff_step, r_clamp, a_calc;
  logic [DistW-1:0]    dx, dy;
  logic [CoordW-1:0]   mul_a, mul_b;
  logic [2*CoordW-1:0] prod;
  logic                div_start, sqrt_start, out_free, out_load, drop;
  logic [DivdW-1:0]    dividend;
  logic [DistW-1:0]    divisor;
  div_res_t            div_res;
  sqrt_res_t           sqrt_res;
  logic [DistW:0]      rsum_x, rsum_y;
  logic                wrap_x, wrap_y;
  logic [DistW-1:0]    rx_nxt, ry_nxt;
  logic [CoordW-1:0]   qx_nxt, qy_nxt, px, py;

  assign eff_step = (step_r == '0) ? RegW'(1) : step_r;
  assign r_clamp  = (residual_r >= eff_step) ? eff_step - 1'b1 : residual_r;
  assign a_calc   = eff_step - r_clamp;

  assign dx = {in_data.vertex_x[CoordW-1], in_data.vertex_x} - {prev_x_r[CoordW-1], prev_x_r};
  assign dy = {in_data.vertex_y[CoordW-1], in_data.vertex_y} - {prev_y_r[CoordW-1], prev_y_r};

  // the one multiplier: squares first, then |delta| times offset or step
  always_comb begin
    case (state_r)
      ST_SQX: begin
        mul_a = mx_r;
        mul_b = mx_r;
      end
      ST_SQY: begin
        mul_a = my_r;
        mul_b = my_r;
      end
      ST_MUL: begin
        mul_a = phase_r[0] ? my_r : mx_r;
        mul_b = CoordW'(phase_r[1] ? eff_step : a_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign sqrt_start = (state_r == ST_SQRTGO);
  assign div_start  = ((state_r == ST_SPLIT) && (d_r >= DistW'(a_calc))) || (state_r == ST_DIVS);
  assign dividend   = (state_r == ST_SPLIT) ? DivdW'(d_r - DistW'(a_calc)) :
                      DivdW'(acc_r[51:0]) + (phase_r[1] ? '0 : DivdW'(d_r[DistW-1:1]));
  assign divisor    = (state_r == ST_SPLIT) ? DistW'(eff_step) : d_r;

  palr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc_r),
    .res      (sqrt_res)
  );

  palr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .res      (div_res)
  );

  // incremental offset: quotient and remainder of |delta| * s / d, advanced by one step
  assign rsum_x = {1'b0, rx_r} + {1'b0, rsx_r};
  assign rsum_y = {1'b0, ry_r} + {1'b0, rsy_r};
  assign wrap_x = rsum_x >= {1'b0, d_r};
  assign wrap_y = rsum_y >= {1'b0, d_r};
  assign rx_nxt = wrap_x ? DistW'(rsum_x - {1'b0, d_r}) : rsum_x[DistW-1:0];
  assign ry_nxt = wrap_y ? DistW'(rsum_y - {1'b0, d_r}) : rsum_y[DistW-1:0];
  assign qx_nxt = qx_r + qsx_r + CoordW'(wrap_x);
  assign qy_nxt = qy_r + qsy_r + CoordW'(wrap_y);
  assign px     = nx_r ? prev_x_r - qx_r : prev_x_r + qx_r;
  assign py     = ny_r ? prev_y_r - qy_r : prev_y_r + qy_r;

  assign out_free = !out_valid_r || out_ready;
  assign out_load = out_free && (state_r inside {ST_EMIT, ST_OUTH, ST_OUTL});
  assign drop     = ({residual_r, 1'b0} < {1'b0, eff_step}) && pushed_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= RegW'(19661);
      tail_r       <= RegW'(6554);
      have_prev_r  <= 1'b0;
      held_valid_r <= 1'b0;
      held_trunc_r <= 1'b0;
      pushed_r     <= '0;
      residual_r   <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_SAMPLE_STEP) step_r <= cfg_data;
        else if (cfg_index == REG_MIN_TAIL) tail_r <= cfg_data;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (!have_prev_r) begin
              if (in_data.last_vertex) begin
                held_valid_r <= 1'b0;
                held_trunc_r <= 1'b0;
                pushed_r     <= '0;
                residual_r   <= '0;
                prev_x_r     <= '0;
                prev_y_r     <= '0;
              end else begin
                prev_x_r    <= in_data.vertex_x;
                prev_y_r    <= in_data.vertex_y;
                have_prev_r <= 1'b1;
              end
            end else begin
              cur_x_r <= in_data.vertex_x;
              cur_y_r <= in_data.vertex_y;
              last_r  <= in_data.last_vertex;
              nx_r    <= dx[DistW-1];
              ny_r    <= dy[DistW-1];
              mx_r    <= dx[DistW-1] ? CoordW'(-dx) : dx[CoordW-1:0];
              my_r    <= dy[DistW-1] ? CoordW'(-dy) : dy[CoordW-1:0];
              if (!held_valid_r) begin
                held_x_r     <= prev_x_r;
                held_y_r     <= prev_y_r;
                held_trunc_r <= 1'b0;
                held_valid_r <= 1'b1;
                pushed_r     <= pushed_r[1] ? pushed_r : pushed_r + 1'b1;
              end
              state_r <= ST_SQX;
            end
          end
        end
        ST_SQX: begin
          acc_r   <= RadW'(prod);
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          acc_r   <= acc_r + RadW'(prod);
          state_r <= ST_SQRTGO;
        end
        ST_SQRTGO: state_r <= ST_SQRTW;
        ST_SQRTW: begin
          if (sqrt_res.done) begin
            d_r     <= sqrt_res.root;
            state_r <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          a_r <= a_calc;
          if (d_r < DistW'(a_calc)) begin
            // segment too short for a sample: absorbed into the leftover
            residual_r <= r_clamp + d_r[RegW-1:0];
            state_r    <= ST_FIN;
          end else begin
            rest_r  <= d_r - DistW'(a_calc);
            state_r <= ST_RESTW;
          end
        end
        ST_RESTW: begin
          if (div_res.done) begin
            residual_r <= div_res.rem[RegW-1:0];
            phase_r    <= '0;
            state_r    <= ST_MUL;
            if (rest_r < DistW'(tail_r)) begin
              cnt_r <= CW'(1);
              tr_r  <= 1'b0;
            end else if (div_res.quot >= DivdW'(MAX_SAMPLES)) begin
              cnt_r <= CW'(MAX_SAMPLES);
              tr_r  <= 1'b1;
            end else begin
              cnt_r <= div_res.quot[CW-1:0] + 1'b1;
              tr_r  <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          acc_r   <= RadW'(prod);
          state_r <= ST_DIVS;
        end
        ST_DIVS: state_r <= ST_DIVW;
        ST_DIVW: begin
          if (div_res.done) begin
            case (phase_r)
              2'd0: begin
                qx_r <= div_res.quot[CoordW-1:0];
                rx_r <= div_res.rem;
              end
              2'd1: begin
                qy_r <= div_res.quot[CoordW-1:0];
                ry_r <= div_res.rem;
              end
              2'd2: begin
                qsx_r <= div_res.quot[CoordW-1:0];
                rsx_r <= div_res.rem;
              end
              default: begin
                qsy_r <= div_res.quot[CoordW-1:0];
                rsy_r <= div_res.rem;
              end
            endcase
            if ((phase_r == 2'd3) || ((phase_r == 2'd1) && (cnt_r == CW'(1)))) begin
              state_r <= ST_EMIT;
            end else begin
              phase_r <= phase_r + 1'b1;
              state_r <= ST_MUL;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data_r.point_x    <= held_x_r;
            out_data_r.point_y    <= held_y_r;
            out_data_r.last_point <= 1'b0;
            out_data_r.truncated  <= held_trunc_r;
            held_x_r     <= px;
            held_y_r     <= py;
            held_trunc_r <= tr_r;
            pushed_r     <= pushed_r[1] ? pushed_r : pushed_r + 1'b1;
            qx_r  <= qx_nxt;
            qy_r  <= qy_nxt;
            rx_r  <= rx_nxt;
            ry_r  <= ry_nxt;
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == CW'(1)) state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
          if (!last_r) state_r <= ST_IDLE;
          else if (held_valid_r && !drop) state_r <= ST_OUTH;
          else state_r <= ST_OUTL;
        end
        ST_OUTH: begin
          if (out_free) begin
            out_data_r.point_x    <= held_x_r;
            out_data_r.point_y    <= held_y_r;
            out_data_r.last_point <= 1'b0;
            out_data_r.truncated  <= held_trunc_r;
            state_r               <= ST_OUTL;
          end
        end
        ST_OUTL: begin
          if (out_free) begin
            out_data_r.point_x    <= cur_x_r;
            out_data_r.point_y    <= cur_y_r;
            out_data_r.last_point <= 1'b1;
            out_data_r.truncated  <= 1'b0;
            have_prev_r  <= 1'b0;
            held_valid_r <= 1'b0;
            held_trunc_r <= 1'b0;
            pushed_r     <= '0;
            residual_r   <= '0;
            prev_x_r     <= '0;
            prev_y_r     <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_emit_has_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (held_valid_r && (cnt_r != '0)))
    else $error("point emitted with nothing held");

  a_dda_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ((rx_r < d_r) && (ry_r < d_r)))
    else $error("offset remainder not below segment length");

  a_path_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUTL) && out_free) |=> (!have_prev_r && !held_valid_r && (pushed_r == '0)))
    else $error("path state not cleared after end vertex");

  a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUTL) && out_free) |=> (out_valid_r && out_data_r.last_point))
    else $error("end vertex not marked last");
`endif

endmodule

/* tb/polyline_arc_length_resampler_tb.sv */
// Self-checking bench for the polyline arc-length resampler.
// Needs palr_pkg and the block itself. It runs a directed table and then random paths
// over several step and tail settings, and checks every point against its own predictor.
module polyline_arc_length_resampler_tb;
  import palr_pkg::*;

  localparam int MaxSamples  = 32;
  localparam int DrainCycles = 600;
  localparam longint CycleLimit = 10_000_000;
  localparam int RandItems   = 480;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  palr_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  palr_out_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IdxW-1:0]   cfg_index = REG_SAMPLE_STEP;
  logic [RegW-1:0]   cfg_data = '0;

  polyline_arc_length_resampler #(.MAX_SAMPLES(MaxSamples)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [RegW-1:0]    step_reg, tail_reg;
  logic signed [31:0] last_x, last_y;
  bit                 have_last;
  longint unsigned    leftover;
  logic signed [31:0] hold_x, hold_y;
  bit                 hold_valid, hold_trunc;
  int unsigned        pushed;

  palr_out_t expected_points[$];
  int        errors = 0;
  longint    cycles = 0;

  task automatic report(input string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic void clear_path();
    last_x = '0; last_y = '0; have_last = 0; leftover = 0;
    hold_x = '0; hold_y = '0; hold_valid = 0; hold_trunc = 0; pushed = 0;
  endfunction

  function automatic void queue_point(logic signed [31:0] x, logic signed [31:0] y,
                                      bit lst, bit tr);
    palr_out_t p;
    p.point_x = x; p.point_y = y; p.last_point = lst; p.truncated = tr;
    expected_points.insert(expected_points.size(), p);
  endfunction

  function automatic void hold_point(logic signed [31:0] x, logic signed [31:0] y, bit tr);
    if (hold_valid) queue_point(hold_x, hold_y, 1'b0, hold_trunc);
    hold_x = x; hold_y = y; hold_trunc = tr; hold_valid = 1;
    if (pushed < 2) pushed++;
  endfunction

  function automatic longint unsigned span_root(logic [65:0] rad);
    logic [67:0]     rem;
    longint unsigned root;
    logic [67:0]     trial;
    rem = '0; root = 0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | rad[2*k +: 2];
      root = root << 1;
      trial = {root, 1'b1};
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [31:0] lerp(logic signed [31:0] p, longint unsigned mag,
                                              bit neg, longint unsigned s,
                                              longint unsigned d);
    logic [127:0] off;
    off = (128'(mag) * 128'(s) + 128'(d / 2)) / 128'(d);
    return neg ? p - off[31:0] : p + off[31:0];
  endfunction

  // works out the points one accepted vertex releases
  function automatic void predict_vertex(palr_in_t v);
    longint          dx, dy;
    bit              nx, ny;
    longint unsigned mx, my, d, stp, r, a, rest, cnt, s;
    logic [65:0]     rad;
    bit              tr, drop;
    stp = (step_reg == 0) ? 1 : longint'(step_reg);
    if (!have_last) begin
      if (v.last_vertex) clear_path();
      else begin
        last_x = v.vertex_x; last_y = v.vertex_y; have_last = 1;
      end
      return;
    end
    dx = longint'(v.vertex_x) - longint'(last_x);
    dy = longint'(v.vertex_y) - longint'(last_y);
    nx = dx < 0; ny = dy < 0;
    mx = nx ? -dx : dx;
    my = ny ? -dy : dy;
    rad = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
    d = span_root(rad);
    if (!hold_valid) hold_point(last_x, last_y, 1'b0);
    r = (leftover >= stp) ? stp - 1 : leftover;
    a = stp - r;
    if (d < a) leftover = r + d;
    else begin
      rest = d - a;
      leftover = rest % stp;
      if (rest < longint'(tail_reg))
        hold_point(lerp(last_x, mx, nx, a, d), lerp(last_y, my, ny, a, d), 1'b0);
      else begin
        cnt = rest / stp + 1;
        tr = cnt > MaxSamples;
        if (tr) cnt = MaxSamples;
        for (longint unsigned j = 0; j < cnt; j++) begin
          s = a + j * stp;
          hold_point(lerp(last_x, mx, nx, s, d), lerp(last_y, my, ny, s, d), tr);
        end
      end
    end
    last_x = v.vertex_x; last_y = v.vertex_y;
    if (v.last_vertex) begin
      drop = (leftover * 2 < stp) && pushed >= 2;
      if (hold_valid && !drop) queue_point(hold_x, hold_y, 1'b0, hold_trunc);
      queue_point(v.vertex_x, v.vertex_y, 1'b1, 1'b0);
      clear_path();
    end
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;

  task automatic send_vertex(input palr_in_t v, input int typed_cnt);
    int gap, before_cnt;
    gap = 0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (!in_ready);
    before_cnt = expected_points.size();
    predict_vertex(v);
    if (typed_cnt >= 0 && expected_points.size() - before_cnt != typed_cnt)
      report($sformatf("vertex %h: predicted %0d points, table says %0d", v,
                       expected_points.size() - before_cnt, typed_cnt));
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [RegW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SAMPLE_STEP) step_reg = val;
    else if (idx == REG_MIN_TAIL) tail_reg = val;
    @(posedge clk);
  endtask

  // wait for every expected point, then let a vertex that releases none finish
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // receiver stall pattern and timeout
  int rx_mode = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    palr_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0)
        report($sformatf("point %h with nothing expected", out_data));
      else begin
        e = expected_points.pop_front();
        if (out_data.point_x !== e.point_x)
          report($sformatf("point_x %h, want %h", out_data.point_x, e.point_x));
        if (out_data.point_y !== e.point_y)
          report($sformatf("point_y %h, want %h", out_data.point_y, e.point_y));
        if (out_data.last_point !== e.last_point)
          report($sformatf("last_point %b, want %b", out_data.last_point, e.last_point));
        if (out_data.truncated !== e.truncated)
          report($sformatf("truncated %b, want %b", out_data.truncated, e.truncated));
      end
    end
  end

  typedef struct {
    int   x, y;
    bit   lst;
    int   typed_cnt;   // -1: predictor alone
  } vertex_row_t;

  localparam int NumRows = 22;
  vertex_row_t directed[NumRows] = '{
    '{0, 0, 1, 0},                                   // lone vertex path
    '{0, 0, 0, 0}, '{65536, 0, 1, -1},
    '{32'h8000_0000, 32'h8000_0000, 0, 0},           // corner to corner
    '{32'h7fff_ffff, 32'h7fff_ffff, 1, -1},
    '{5, 5, 0, 0}, '{5, 5, 0, -1}, '{5, 5, 1, -1},   // zero-length segments
    '{0, 0, 0, 0}, '{1000, 0, 0, -1},                // short segments absorbed
    '{2000, 0, 0, -1}, '{30000, 0, 1, -1},
    '{0, 0, 0, 0}, '{22661, 0, 1, -1},               // tail below limit
    '{0, 0, 0, 0}, '{-70000, -40000, 0, -1},
    '{-100000, 50000, 1, -1},
    '{32'h7fff_ffff, 32'h8000_0000, 0, 0}, '{0, 0, 1, -1},
    '{3, -7, 0, 0}, '{200000, -150000, 0, -1},       // left open across the write
    '{-1, -1, 0, -1}
  };

  typedef struct { logic [RegW-1:0] stp, tail; } setting_t;
  localparam int NumSettings = 8;
  setting_t settings[NumSettings] = '{
    '{20'd2000, 20'd655360 & 20'hfffff}, // step lowered mid-path
    '{20'd65536, 20'd0},
    '{20'd655360, 20'd655360},
    '{20'd1, 20'd0},
    '{20'd0, 20'd100},
    '{20'd8000, 20'd655360},
    '{20'd19661, 20'd6554},
    '{20'd300000, 20'd20000}
  };

  function automatic palr_in_t next_random_vertex(inout int path_left,
                                                  inout logic signed [31:0] px,
                                                  inout logic signed [31:0] py);
    palr_in_t        v;
    longint unsigned stp;
    int              mode;
    stp = (step_reg == 0) ? 1 : step_reg;
    mode = $urandom_range(0, 99);
    if (path_left == 0) path_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
    if (mode < 8 || path_left == 0) begin
      v.vertex_x = $urandom; v.vertex_y = $urandom;
    end else if (mode < 14) begin
      v.vertex_x = px + $urandom_range(0, 2) - 1;
      v.vertex_y = py;
    end else begin
      v.vertex_x = px + ($urandom_range(0, 1) ? 1 : -1) *
                   int'(stp * $urandom_range(0, 4) + $urandom % stp);
      v.vertex_y = py + ($urandom_range(0, 1) ? 1 : -1) *
                   int'(stp * $urandom_range(0, 3) + $urandom % stp);
    end
    path_left--;
    v.last_vertex = (path_left == 0);
    px = v.vertex_x; py = v.vertex_y;
    return v;
  endfunction

  initial begin
    palr_in_t           v;
    int                 path_left;
    logic signed [31:0] px, py;
    step_reg = 20'd19661;
    tail_reg = 20'd6554;
    clear_path();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      v.vertex_x = directed[i].x;
      v.vertex_y = directed[i].y;
      v.last_vertex = directed[i].lst;
      send_vertex(v, directed[i].typed_cnt);
    end

    path_left = 1;
    px = '0; py = '0;
    for (int ph = 0; ph < NumSettings; ph++) begin
      drain();
      write_reg(REG_SAMPLE_STEP, settings[ph].stp);
      write_reg(REG_MIN_TAIL, settings[ph].tail);
      for (int k = 0; k < RandItems / NumSettings; k++) begin
        v = next_random_vertex(path_left, px, py);
        send_vertex(v, -1);
      end
    end
    drain();

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hdl/palr_pkg.sv
hdl/palr_div.sv
hdl/palr_sqrt.sv
hdl/polyline_arc_length_resampler.sv
tb/polyline_arc_length_resampler_tb.sv
